### rtl/core/dual_range_distance_averager_core_defines.svh
// ----------------------------------------------------------------------------
// Dual-range distance averager assertion macros
// Shared property wrappers for the core's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DUAL_RANGE_DISTANCE_AVERAGER_CORE_DEFINES_SVH
`define DUAL_RANGE_DISTANCE_AVERAGER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DRDA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define DRDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/drda_pkg.sv
// ----------------------------------------------------------------------------
// Dual-range distance averager package
// Shared sizes, payload types, register indexes and the root table.
// ----------------------------------------------------------------------------
`default_nettype none
package drda_pkg;

  localparam int WINDOW      = 16;
  localparam int SAMPLE_BITS = 10;
  localparam int SLOT_BITS   = $clog2(WINDOW);
  localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
  localparam int MEAN_BITS   = 14;
  localparam int FRAC_BITS   = 16;
  localparam int GAIN_BITS   = 24;
  localparam int EXP_BITS    = 16;
  localparam int DIST_BITS   = 24;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_GAIN      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_EXPONENT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_GAIN       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_EXPONENT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_THRESHOLD  = 3'd5;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_short;
    logic [SAMPLE_BITS-1:0] sample_long;
  } sample_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 from_short;
    logic                 saturated;
  } result_t;

  typedef struct packed {
    logic [MEAN_BITS-1:0]       mean;
    logic [GAIN_BITS-1:0]       gain;
    logic signed [EXP_BITS-1:0] exponent;
  } pw_req_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 sat;
  } pw_rsp_t;

  // Floor integer square root, elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = v;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > rem) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (rem >= res + bit_v) begin
          rem = rem - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // Entry j holds 2^(2^-(j+1)) in Q1.30.
  function automatic logic [FRAC_BITS-1:0][30:0] build_root_rom();
    logic [63:0] r;
    logic [FRAC_BITS-1:0][30:0] rom;
    r = isqrt64(64'd1 << 61);
    rom[0] = r[30:0];
    for (int j = 1; j < FRAC_BITS; j++) begin
      r = isqrt64(r << 30);
      rom[j] = r[30:0];
    end
    return rom;
  endfunction

  localparam logic [FRAC_BITS-1:0][30:0] ROOT_ROM = build_root_rom();

endpackage
`default_nettype wire

### rtl/core/drda_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 32x32 multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none
module drda_mul (
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [63:0] prod
);
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end
endmodule
`default_nettype wire

### rtl/core/drda_window.sv
// ----------------------------------------------------------------------------
// Sliding windows
// Two sample windows with running sums and a shared write position.
// ----------------------------------------------------------------------------
`default_nettype none
module drda_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  drda_pkg::sample_t             sample,
  output logic [drda_pkg::MEAN_BITS-1:0] short_mean,
  output logic [drda_pkg::MEAN_BITS-1:0] long_mean,
  output logic                          wrap_next
);
  import drda_pkg::*;

  logic [SAMPLE_BITS-1:0] short_window [WINDOW];
  logic [SAMPLE_BITS-1:0] long_window  [WINDOW];
  logic [SUM_BITS-1:0]    short_sum;
  logic [SUM_BITS-1:0]    long_sum;
  logic [SLOT_BITS-1:0]   write_slot;
  logic [SLOT_BITS-1:0]   write_slot_next;

  always_comb begin
    if (write_slot == SLOT_BITS'(WINDOW - 1)) write_slot_next = '0;
    else write_slot_next = write_slot + 1'b1;
  end

  assign wrap_next = (write_slot_next == SLOT_BITS'(WINDOW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        short_window[i] <= '0;
        long_window[i]  <= '0;
      end
      short_sum  <= '0;
      long_sum   <= '0;
      write_slot <= '0;
    end else if (push) begin
      short_sum <= short_sum - SUM_BITS'(short_window[write_slot_next])
                   + SUM_BITS'(sample.sample_short);
      long_sum  <= long_sum - SUM_BITS'(long_window[write_slot_next])
                   + SUM_BITS'(sample.sample_long);
      short_window[write_slot_next] <= sample.sample_short;
      long_window[write_slot_next]  <= sample.sample_long;
      write_slot <= write_slot_next;
    end
  end

  // Q10.4 mean of the window
  assign short_mean = MEAN_BITS'({short_sum, 4'b0} / WINDOW);
  assign long_mean  = MEAN_BITS'({long_sum, 4'b0} / WINDOW);
endmodule
`default_nettype wire

### rtl/core/drda_power.sv
// ----------------------------------------------------------------------------
// Power-law evaluator
// Computes gain * mean^exponent as exp2(b*log2(m)) on one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module drda_power (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  drda_pkg::pw_req_t req,
  output logic              busy,
  output logic              done,
  output drda_pkg::pw_rsp_t rsp
);
  import drda_pkg::*;

  localparam logic [3:0] P_IDLE    = 4'd0;
  localparam logic [3:0] P_SQ_ISS  = 4'd1;
  localparam logic [3:0] P_SQ_WAIT = 4'd2;
  localparam logic [3:0] P_LG_ISS  = 4'd3;
  localparam logic [3:0] P_LG_WAIT = 4'd4;
  localparam logic [3:0] P_EX_ISS  = 4'd5;
  localparam logic [3:0] P_EX_WAIT = 4'd6;
  localparam logic [3:0] P_FN_ISS  = 4'd7;
  localparam logic [3:0] P_FN_WAIT = 4'd8;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  logic [3:0]           state;
  logic [3:0]           cnt;
  logic [3:0]           n;
  logic [30:0]          x;
  logic [FRAC_BITS-1:0] frac;
  logic signed [8:0]    k;
  logic [FRAC_BITS-1:0] f;
  logic [30:0]          p;

  logic [3:0]           n_calc;
  logic [30:0]          x_init;
  logic [31:0]          sq;
  logic signed [20:0]   lg;
  logic signed [24:0]   e;
  logic signed [31:0]   op_a;
  logic signed [31:0]   op_b;
  logic signed [63:0]   prod;
  logic [54:0]          fin_prod;
  logic [8:0]           shamt;
  logic [54:0]          shifted;

  drda_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Leading one of the mean
  always_comb begin
    n_calc = '0;
    for (int i = 0; i < MEAN_BITS; i++) begin
      if (req.mean[i]) n_calc = 4'(i);
    end
  end

  assign x_init = 31'(req.mean) << (5'd30 - {1'b0, n_calc});
  assign sq     = prod[61:30];
  assign lg     = {5'({1'b0, n} - 5'd4), frac};
  assign e      = prod[36:12];
  assign fin_prod = prod[54:0];
  assign shamt  = 9'sd30 - k;
  assign shifted = fin_prod >> shamt[5:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      P_SQ_ISS: begin
        op_a = {1'b0, x};
        op_b = {1'b0, x};
      end
      P_LG_ISS: begin
        op_a = 32'(req.exponent);
        op_b = 32'(lg);
      end
      P_EX_ISS: begin
        op_a = {1'b0, p};
        op_b = f[4'd15 - cnt] ? {1'b0, ROOT_ROM[cnt]} : {1'b0, ONE_Q30};
      end
      P_FN_ISS: begin
        op_a = {8'b0, req.gain};
        op_b = {1'b0, p};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign busy = (state != P_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        P_IDLE: begin
          if (start) begin
            if (req.mean == '0) begin
              // zero mean: saturate, pass the gain, or give zero
              rsp.sat      <= req.exponent < 0;
              rsp.distance <= (req.exponent < 0) ? DIST_MAX :
                              (req.exponent == 0) ? req.gain : '0;
              done         <= 1'b1;
            end else begin
              n     <= n_calc;
              x     <= x_init;
              frac  <= '0;
              cnt   <= '0;
              state <= P_SQ_ISS;
            end
          end
        end
        P_SQ_ISS: state <= P_SQ_WAIT;
        P_SQ_WAIT: begin
          if (sq[31]) begin
            x    <= sq[31:1];
            frac <= {frac[FRAC_BITS-2:0], 1'b1};
          end else begin
            x    <= sq[30:0];
            frac <= {frac[FRAC_BITS-2:0], 1'b0};
          end
          cnt   <= cnt + 1'b1;
          state <= (cnt == 4'd15) ? P_LG_ISS : P_SQ_ISS;
        end
        P_LG_ISS: state <= P_LG_WAIT;
        P_LG_WAIT: begin
          k     <= e[24:16];
          f     <= e[15:0];
          p     <= ONE_Q30;
          cnt   <= '0;
          state <= P_EX_ISS;
        end
        P_EX_ISS: state <= P_EX_WAIT;
        P_EX_WAIT: begin
          p     <= prod[60:30];
          cnt   <= cnt + 1'b1;
          state <= (cnt == 4'd15) ? P_FN_ISS : P_EX_ISS;
        end
        P_FN_ISS: state <= P_FN_WAIT;
        P_FN_WAIT: begin
          if (fin_prod == '0) begin
            rsp.distance <= '0;
            rsp.sat      <= 1'b0;
          end else if (k >= 9'sd30) begin
            rsp.distance <= DIST_MAX;
            rsp.sat      <= 1'b1;
          end else if (k <= -9'sd34) begin
            rsp.distance <= '0;
            rsp.sat      <= 1'b0;
          end else if (shifted > 55'(DIST_MAX)) begin
            rsp.distance <= DIST_MAX;
            rsp.sat      <= 1'b1;
          end else begin
            rsp.distance <= shifted[DIST_BITS-1:0];
            rsp.sat      <= 1'b0;
          end
          done  <= 1'b1;
          state <= P_IDLE;
        end
        default: state <= P_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/dual_range_distance_averager_core.sv
// No new sample is taken until the current item has been handed to the result register;
// the shared multiplier inside the power-law sequencer handles 34 multiplies per range.
// Warm-up items (before the window position first reaches its last slot) only fill the windows.
// Reset (rst, synchronous, active high) clears windows, sums, position, registers.
// ----------------------------------------------------------------------------
// Dual-range distance averager core
// Averages short and long range samples and converts the means to distance.
// ----------------------------------------------------------------------------
`default_nettype none
module dual_range_distance_averager_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  drda_pkg::sample_t                sample_data,
  output logic                             result_valid,
  input  logic                             result_stall,
  output drda_pkg::result_t                result_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [drda_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [drda_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import drda_pkg::*;
  `include "dual_range_distance_averager_core_defines.svh"

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_SHORT_WAIT = 3'd2;
  localparam logic [2:0] ST_LONG       = 3'd3;
  localparam logic [2:0] ST_LONG_WAIT  = 3'd4;
  localparam logic [2:0] ST_DONE       = 3'd5;

  logic [2:0]                 state;
  logic                       warming_up;
  logic [GAIN_BITS-1:0]       short_gain;
  logic signed [EXP_BITS-1:0] short_exponent;
  logic [GAIN_BITS-1:0]       long_gain;
  logic signed [EXP_BITS-1:0] long_exponent;
  logic [MEAN_BITS-1:0]       short_threshold;
  logic [MEAN_BITS-1:0]       long_threshold;
  pw_rsp_t                    short_rsp;

  logic                 sample_accept;
  logic                 wrap_next;
  logic [MEAN_BITS-1:0] short_mean;
  logic [MEAN_BITS-1:0] long_mean;
  logic                 pw_start;
  logic                 pw_busy;
  logic                 pw_done;
  pw_req_t              pw_req;
  pw_rsp_t              pw_rsp;
  logic                 pick_short;

  // Registers take writes at any time; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_gain      <= '0;
      short_exponent  <= '0;
      long_gain       <= '0;
      long_exponent   <= '0;
      short_threshold <= '0;
      long_threshold  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHORT_GAIN:      short_gain      <= cfg_data[GAIN_BITS-1:0];
        REG_SHORT_EXPONENT:  short_exponent  <= cfg_data[EXP_BITS-1:0];
        REG_LONG_GAIN:       long_gain       <= cfg_data[GAIN_BITS-1:0];
        REG_LONG_EXPONENT:   long_exponent   <= cfg_data[EXP_BITS-1:0];
        REG_SHORT_THRESHOLD: short_threshold <= cfg_data[MEAN_BITS-1:0];
        REG_LONG_THRESHOLD:  long_threshold  <= cfg_data[MEAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Take a transfer only between items; the result register stands apart.
  assign sample_stall  = (state != ST_IDLE);
  assign sample_accept = sample_valid && !sample_stall;

  drda_window u_window (
    .clk        (clk),
    .rst        (rst),
    .push       (sample_accept),
    .sample     (sample_data),
    .short_mean (short_mean),
    .long_mean  (long_mean),
    .wrap_next  (wrap_next)
  );

  // Feed the evaluator one range at a time: short first, then long.
  assign pw_start = (state == ST_SHORT) || (state == ST_LONG);
  always_comb begin
    if (state == ST_LONG || state == ST_LONG_WAIT) begin
      pw_req.mean     = long_mean;
      pw_req.gain     = long_gain;
      pw_req.exponent = long_exponent;
    end else begin
      pw_req.mean     = short_mean;
      pw_req.gain     = short_gain;
      pw_req.exponent = short_exponent;
    end
  end

  drda_power u_power (
    .clk   (clk),
    .rst   (rst),
    .start (pw_start),
    .req   (pw_req),
    .busy  (pw_busy),
    .done  (pw_done),
    .rsp   (pw_rsp)
  );

  assign pick_short = (short_mean > short_threshold) && (long_mean > long_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      warming_up   <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      // Raise valid for a finished item; drop it once the far side takes it.
      if (state == ST_DONE && (!result_valid || !result_stall)) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (sample_accept) begin
            if (!warming_up || wrap_next) begin
              warming_up <= 1'b0;
              state      <= ST_SHORT;
            end
          end
        end
        ST_SHORT: state <= ST_SHORT_WAIT;
        ST_SHORT_WAIT: begin
          if (pw_done) begin
            short_rsp <= pw_rsp;
            state     <= ST_LONG;
          end
        end
        ST_LONG: state <= ST_LONG_WAIT;
        ST_LONG_WAIT: begin
          if (pw_done) state <= ST_DONE;
        end
        ST_DONE: begin
          // Hold the finished item until the result register frees up.
          if (!result_valid || !result_stall) begin
            result_data.from_short <= pick_short;
            result_data.distance   <= pick_short ? short_rsp.distance : pw_rsp.distance;
            result_data.saturated  <= pick_short ? short_rsp.sat : pw_rsp.sat;
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `DRDA_ASSERT_SAME(a_idle_unit_quiet, state == ST_IDLE, !pw_busy,
                    "evaluator busy while core idle")
  `DRDA_ASSERT_NEXT(a_wrap_starts_work, sample_accept && wrap_next, state == ST_SHORT,
                    "window wrap did not start a computation")
  `DRDA_ASSERT_SAME(a_sat_is_max, result_valid && result_data.saturated,
                    result_data.distance == DIST_MAX, "saturated result below maximum")
  `DRDA_ASSERT_NEXT(a_done_leaves_wait, pw_done && state == ST_LONG_WAIT, state == ST_DONE,
                    "long range done not followed by result stage")
endmodule
`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Dual-range distance averager testbench
// Drives sample transfers with random bursts and gaps, stalls the result side,
// predicts each result from an independent model of the windows and the
// power-law conversion, and compares every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import drda_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD = 4000;

  typedef struct packed {
    logic                 sat;
    logic [DIST_BITS-1:0] distance;
  } conv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  dual_range_distance_averager_core u_top (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample_data(sample_data),
    .result_valid(result_valid), .result_stall(result_stall), .result_data(result_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Model state: windows, sums, slot, warm-up flag and register copies.
  int unsigned short_win[WINDOW];
  int unsigned long_win[WINDOW];
  int unsigned short_acc, long_acc, slot;
  bit warm = 1'b1;
  logic [GAIN_BITS-1:0] gain_s, gain_l;
  logic signed [EXP_BITS-1:0] expo_s, expo_l;
  logic [MEAN_BITS-1:0] thr_s, thr_l;
  longint unsigned roots[1:FRAC_BITS];

  sample_t sample_queue[$];
  result_t pending_results[$];
  int pushed_count = 0;
  int accepted_count = 0;
  int mismatches = 0;
  int cycle_count = 0;
  bit took = 1'b0;
  bit hold_request = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint floor_quot(longint v, longint d);
    longint q;
    q = v / d;
    if ((v % d) != 0 && v < 0) q = q - 1;
    return q;
  endfunction

  // a * m^b via exp2(b * log2(m)), m in Q10.4.
  function automatic conv_t to_distance(logic [GAIN_BITS-1:0] a,
                                        logic signed [EXP_BITS-1:0] b, int unsigned m);
    int n;
    longint unsigned x, frac, p, prod;
    longint lg, e, k, f;
    conv_t r;
    r = '0;
    if (m == 0) begin
      if (b < 0) begin
        r.sat = 1'b1;
        r.distance = DIST_MAX;
      end else if (b == 0) begin
        r.distance = a;
      end
      return r;
    end
    n = 0;
    while (n < 31 && (m >> (n + 1)) != 0) n++;
    x = longint'(m) << (30 - n);
    frac = 0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd2 << 30)) begin
        frac = frac | 1;
        x = x >> 1;
      end
    end
    lg = (longint'(n) - 4) * 65536 + longint'(frac);
    e = floor_quot(longint'(b) * lg, 4096);
    k = floor_quot(e, 65536);
    f = e - k * 65536;
    p = 64'd1 << 30;
    for (int i = 1; i <= FRAC_BITS; i++)
      if (((f >> (FRAC_BITS - i)) & 1) != 0) p = (p * roots[i]) >> 30;
    prod = longint'(a) * p;
    if (prod == 0) return r;
    if (k >= 30) begin
      r.sat = 1'b1;
      r.distance = DIST_MAX;
      return r;
    end
    if (30 - k >= 64) return r;
    prod = prod >> (30 - k);
    if (prod > longint'(DIST_MAX)) begin
      r.sat = 1'b1;
      r.distance = DIST_MAX;
    end else begin
      r.distance = prod[DIST_BITS-1:0];
    end
    return r;
  endfunction

  // Advance both windows by one sample and queue the result it causes, if any.
  task automatic advance_windows(sample_t s);
    int unsigned ms, ml;
    conv_t ds, dl;
    bit pick;
    result_t res;
    slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    short_acc = short_acc - short_win[slot] + s.sample_short;
    long_acc = long_acc - long_win[slot] + s.sample_long;
    short_win[slot] = s.sample_short;
    long_win[slot] = s.sample_long;
    if (warm) begin
      if (slot != WINDOW - 1) return;
      warm = 1'b0;
    end
    ms = (short_acc * 16) / WINDOW;
    ml = (long_acc * 16) / WINDOW;
    ds = to_distance(gain_s, expo_s, ms);
    dl = to_distance(gain_l, expo_l, ml);
    pick = (ms > thr_s) && (ml > thr_l);
    res.distance = pick ? ds.distance : dl.distance;
    res.from_short = pick;
    res.saturated = pick ? ds.sat : dl.sat;
    pending_results.push_back(res);
  endtask

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dual_range_distance_averager_core verification failed");
      $finish;
    end
  end

  // Sample acceptance: predict from the payload that actually transferred.
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) begin
      advance_windows(sample_data);
      accepted_count++;
      took = 1'b1;
    end
  end

  // Sample driver: bursts of random length, random gaps, hold payload while stalled.
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || took) begin
      took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        sample_valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        sample_valid <= 1'b1;
        sample_data <= sample_queue.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern: a random mode, redrawn when its count runs out; a long hold on request.
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (mode_left == 0) begin
      mode_left = 64;
      stall_mode = $urandom_range(0, 3);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= $urandom_range(0, 1);
      endcase
    end
  end

  // Result monitor: compare each transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_data);
      end else begin
        if (result_data !== pending_results[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", pending_results[0], result_data);
        end
        void'(pending_results.pop_front());
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SHORT_GAIN: gain_s = val;
      REG_SHORT_EXPONENT: expo_s = val[EXP_BITS-1:0];
      REG_LONG_GAIN: gain_l = val;
      REG_LONG_EXPONENT: expo_l = val[EXP_BITS-1:0];
      REG_SHORT_THRESHOLD: thr_s = val[MEAN_BITS-1:0];
      REG_LONG_THRESHOLD: thr_l = val[MEAN_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(logic [23:0] sg, logic [23:0] se, logic [23:0] lg,
                         logic [23:0] le, logic [23:0] st, logic [23:0] lt);
    write_reg(REG_SHORT_GAIN, sg);
    write_reg(REG_SHORT_EXPONENT, se);
    write_reg(REG_LONG_GAIN, lg);
    write_reg(REG_LONG_EXPONENT, le);
    write_reg(REG_SHORT_THRESHOLD, st);
    write_reg(REG_LONG_THRESHOLD, lt);
  endtask

  task automatic push_item(int unsigned s, int unsigned l, int count);
    sample_t it;
    it.sample_short = s[SAMPLE_BITS-1:0];
    it.sample_long = l[SAMPLE_BITS-1:0];
    repeat (count) begin
      sample_queue.push_back(it);
      pushed_count++;
    end
  endtask

  // Wait for every item and result, then let the block settle.
  task automatic drain();
    while (accepted_count != pushed_count || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 24'd0;
      1: return DIST_MAX;
      2: return 24'($urandom_range(1, 4096));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_exponent();
    case ($urandom_range(0, 5))
      0: return 24'h008000;
      1: return 24'h007FFF;
      2: return 24'd0;
      3: return 24'($urandom);
      default: return 24'($urandom_range(0, 16384) - 8192);
    endcase
  endfunction

  function automatic logic [23:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return 24'd0;
      1: return 24'h3FFF;
      2: return 24'($urandom);
      default: return 24'(16 * $urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    int zero_run, level, mode;
    roots[1] = int_sqrt(64'd1 << 61);
    for (int j = 2; j <= FRAC_BITS; j++) roots[j] = int_sqrt(roots[j-1] << 30);
    for (int i = 0; i < WINDOW; i++) begin
      short_win[i] = 0;
      long_win[i] = 0;
    end
    short_acc = 0;
    long_acc = 0;
    slot = 0;
    gain_s = '0; gain_l = '0; expo_s = '0; expo_l = '0; thr_s = '0; thr_l = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero means at the end of warm-up: the long side is picked, and its zero exponent gives a.
    set_all(24'h000100, 24'hFFF000, 24'h000100, 24'd0, 24'd0, 24'd0);
    write_reg(REG_UNUSED, 24'hABCDEF);
    push_item(0, 0, 16);
    push_item(1023, 1023, 4);
    drain();

    // Zero mean with positive exponent and full gain, then huge results that clip.
    set_all(24'd0, 24'hFF1000, DIST_MAX, 24'h007FFF, 24'h003FFF, 24'd0);
    push_item(0, 0, 16);
    push_item(1023, 1023, 8);
    drain();

    // Threshold tie on both sides, tiny results, and one side above threshold.
    set_all(24'd1, 24'h008000, 24'd1, 24'h007FFF, 24'(16 * 512), 24'(16 * 512));
    push_item(512, 512, 16);
    push_item(513, 513, 16);
    push_item(1023, 0, 4);
    drain();

    // Random phases with random settings.
    for (int ph = 0; ph < 8; ph++) begin
      set_all(pick_gain(), pick_exponent(), pick_gain(), pick_exponent(),
              pick_threshold(), pick_threshold());
      if (ph == 3) hold_request = 1'b1;
      zero_run = 0;
      level = $urandom_range(0, 1023);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < 110; i++) begin
        if (zero_run == 0 && $urandom_range(0, 60) == 0) zero_run = $urandom_range(16, 20);
        if (zero_run > 0) begin
          zero_run--;
          push_item(0, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 1023), 1);
        end else if (mode == 0) begin
          push_item($urandom_range(0, 1023), $urandom_range(0, 1023), 1);
        end else if (mode == 1) begin
          push_item($urandom_range(0, 15), $urandom_range(0, 15), 1);
        end else begin
          push_item((level + $urandom_range(0, 8)) % 1024,
                    (1023 - level + $urandom_range(0, 8)) % 1024, 1);
        end
      end
      drain();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("dual_range_distance_averager_core verification clean");
    end else begin
      $display("dual_range_distance_averager_core verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/drda_pkg.sv
rtl/core/drda_mul.sv
rtl/core/drda_window.sv
rtl/core/drda_power.sv
rtl/core/dual_range_distance_averager_core.sv
sim/testbench.sv
